FILE: rtl/irlga_pkg.sv
`default_nettype none

package irlga_pkg;

  // Field and state widths
  localparam int ADC_BITS     = 10;
  localparam int MAX_READINGS = 64;
  localparam int FRAC_BITS    = 4;
  localparam int RAW_W        = 10;
  localparam int DIST_W       = 16;
  localparam int TALLY_W      = $clog2(MAX_READINGS + 1);
  localparam int POS_W        = $clog2(MAX_READINGS);
  localparam int SUM_W        = DIST_W + POS_W;
  localparam int CURVE_W      = 3;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int GATE_W       = DIST_W + CFG_DATA_W;

  // Fixed-point formats of the log/exp datapath
  localparam int LOG_FRAC_W = 24;
  localparam int LOG_INT_W  = $clog2(ADC_BITS);
  localparam int Q_FRAC     = 30;
  localparam int MANT_W     = Q_FRAC + 1;
  localparam int MUL_W      = 2 * MANT_W;
  localparam int TOP_W      = 29;
  localparam int SLOPE_W    = 25;
  localparam int SHIFT_W    = $clog2(DIST_W);
  localparam int STEP_W     = $clog2(SUM_W);

  localparam int CURVE_COUNT = 6;
  localparam int CURVE_LAST  = 5;

  localparam logic [DIST_W-1:0]     DIST_MAX       = '1;
  localparam logic [CFG_DATA_W-1:0] READINGS_RESET = 7'd25;
  localparam logic [CFG_DATA_W-1:0] PERCENT_SCALE  = 7'd100;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_CURVE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_READINGS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE    = 2'd2;

  // Curve coefficients as decimals scaled by 1e10
  localparam logic [63:0] DEC_SCALE   = 64'd10000000000;
  localparam logic [63:0] LOG2_10_DEC = 64'd33219280949;
  localparam logic [63:0] OFFSET_DEC [CURVE_COUNT] = '{
    64'd36515057200, 64'd38809406350, 64'd36067410490,
    64'd40164180500, 64'd43216189610, 64'd42230622890
  };
  localparam logic [63:0] SLOPE_DEC [CURVE_COUNT] = '{
    64'd9696596938,  64'd10502688370, 64'd9444125255,
    64'd11067601980, 64'd10973048770, 64'd10593915270
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG_INIT,
    ST_LOG_SQ,
    ST_SLOPE,
    ST_EXP_SETUP,
    ST_EXP_MUL,
    ST_EXP_OUT,
    ST_GATE_MUL,
    ST_GATE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef logic [0:CURVE_COUNT-1][TOP_W-1:0]   top_tab_t;
  typedef logic [0:CURVE_COUNT-1][SLOPE_W-1:0] slope_tab_t;
  typedef logic [0:LOG_FRAC_W-1][MANT_W-1:0]   root_tab_t;

  // Scaled decimal to Q.24, truncated
  function automatic logic [63:0] dec_to_q24(input logic [63:0] d);
    return (d * (64'd1 << LOG_FRAC_W)) / DEC_SCALE;
  endfunction

  // Integer square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem_w;
    logic [63:0] root_w;
    logic [63:0] bit_w;
    rem_w  = v;
    root_w = '0;
    bit_w  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem_w >= root_w + bit_w) begin
        rem_w  = rem_w - (root_w + bit_w);
        root_w = (root_w >> 1) + bit_w;
      end else begin
        root_w = root_w >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root_w;
  endfunction

  // Exponent offset per curve: c0*log2(10) plus the output fraction bits, Q.24
  function automatic top_tab_t build_top_tab();
    top_tab_t    t;
    logic [63:0] a;
    for (int c = 0; c < CURVE_COUNT; c++) begin
      a    = (dec_to_q24(OFFSET_DEC[c]) * dec_to_q24(LOG2_10_DEC)) >> LOG_FRAC_W;
      t[c] = TOP_W'(a + (64'(FRAC_BITS) << LOG_FRAC_W));
    end
    return t;
  endfunction

  // Slope magnitude per curve, Q.24
  function automatic slope_tab_t build_slope_tab();
    slope_tab_t t;
    for (int c = 0; c < CURVE_COUNT; c++) begin
      t[c] = SLOPE_W'(dec_to_q24(SLOPE_DEC[c]));
    end
    return t;
  endfunction

  // Roots 2^(2^-i) in Q.30 for i = 1..24
  function automatic root_tab_t build_root_tab();
    root_tab_t   t;
    logic [63:0] r;
    r = isqrt64(64'd1 << (2 * Q_FRAC + 1));
    for (int k = 0; k < LOG_FRAC_W; k++) begin
      t[k] = r[MANT_W-1:0];
      r    = isqrt64(r << Q_FRAC);
    end
    return t;
  endfunction

  localparam top_tab_t   CURVE_TOP   = build_top_tab();
  localparam slope_tab_t CURVE_SLOPE = build_slope_tab();
  localparam root_tab_t  EXP_ROOT    = build_root_tab();

endpackage

`default_nettype wire

FILE: rtl/ir_range_linearize_gated_average_unit.sv
// Infrared range linearizer with gated window mean, one converter sample per item.
// After normalization, 24 log2 squarings, a slope product, 24 exp2 products and the gate;
// a zero sample or out-of-range exponent skips to the gate. A window-closing sample adds
// the 22-step divider (skipped if none accepted) and the output load. Input stalls until
// done. All products use one shared 31x31 multiplier. Reset (synchronous, active high) clears
// history and window, drops the output item and loads curve 0, 25 readings, tolerance 0.
`default_nettype none

module ir_range_linearize_gated_average_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [irlga_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [irlga_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [irlga_pkg::RAW_W-1:0]       raw_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [irlga_pkg::DIST_W-1:0]      mean_distance,
  output logic [irlga_pkg::TALLY_W-1:0]     accepted_readings,
  output logic                              none_accepted
);
  import irlga_pkg::*;

  state_t state;
  state_t state_next;

  // Configuration
  logic [CURVE_W-1:0]    sensor_curve;
  logic [CFG_DATA_W-1:0] readings;
  logic [CFG_DATA_W-1:0] tolerance;

  // Sequencer and datapath registers
  logic [STEP_W-1:0]     cnt;
  logic [ADC_BITS-1:0]   raw_q;
  logic [MANT_W-1:0]     x;
  logic [LOG_FRAC_W-1:0] frac;
  logic [LOG_INT_W-1:0]  log_int;
  logic [TOP_W-1:0]      expo;
  logic [SHIFT_W-1:0]    shift_n;
  logic [MANT_W-1:0]     m;
  logic [DIST_W-1:0]     distance;
  logic [GATE_W-1:0]     tol_prod;
  logic [SUM_W-1:0]      quot;
  logic [TALLY_W-1:0]    rem;

  // Window state
  logic [DIST_W-1:0]     prev;
  logic [SUM_W-1:0]      sum;
  logic [TALLY_W-1:0]    tally;
  logic [POS_W-1:0]      position;

  // Combinational
  logic [MANT_W-1:0]          mul_a;
  logic [MANT_W-1:0]          mul_b;
  logic [MUL_W-1:0]           prod;
  logic [MANT_W:0]            sq;
  logic [MANT_W-1:0]          x_next;
  logic [CURVE_W-1:0]         curve_sel;
  logic [LOG_INT_W-1:0]       lead;
  logic [ADC_BITS+Q_FRAC-1:0] norm_wide;
  logic                       raw_zero;
  logic [TOP_W-1:0]           expo_top;
  logic [TOP_W-1:0]           exp_diff;
  logic                       exp_neg;
  logic                       exp_big;
  logic [Q_FRAC+DIST_W-1:0]   shifted_m;
  logic [GATE_W-1:0]          dist_x100;
  logic                       pass;
  logic [SUM_W-1:0]           sum_new;
  logic [TALLY_W-1:0]         tally_new;
  logic [TALLY_W-1:0]         pos_inc;
  logic [TALLY_W-1:0]         len_eff;
  logic                       window_end;
  logic [TALLY_W:0]           div_shift;
  logic [TALLY_W:0]           div_diff;
  logic                       div_ok;
  logic                       out_free;
  logic                       last_step;
  logic                       step_state;

  // Shared multiplier and its result slices
  assign prod   = mul_a * mul_b;
  assign sq     = prod[MUL_W-1:Q_FRAC];
  assign x_next = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];

  assign curve_sel = (sensor_curve > CURVE_W'(CURVE_LAST)) ? CURVE_W'(CURVE_LAST)
                                                            : sensor_curve;

  // Normalize the sample to a Q.30 mantissa in [1, 2)
  always_comb begin
    lead = '0;
    for (int i = 0; i < ADC_BITS; i++) begin
      if (raw_q[i]) lead = LOG_INT_W'(i);
    end
  end
  assign norm_wide = {raw_q, {Q_FRAC{1'b0}}} >> lead;
  assign raw_zero  = (raw_q == '0);

  // Base-2 exponent from offset and slope term
  assign expo_top = CURVE_TOP[curve_sel];
  assign exp_neg  = (expo_top < expo);
  assign exp_diff = expo_top - expo;
  assign exp_big  = (exp_diff[TOP_W-1:LOG_FRAC_W] >= (TOP_W-LOG_FRAC_W)'(DIST_W));

  // Scale mantissa by the integer exponent
  assign shifted_m = {{(DIST_W-1){1'b0}}, m} << shift_n;

  // Acceptance gate and window bookkeeping
  assign dist_x100  = GATE_W'(distance) * GATE_W'(PERCENT_SCALE);
  assign pass       = (dist_x100 >= tol_prod);
  assign sum_new    = pass ? sum + SUM_W'(distance) : sum;
  assign tally_new  = pass ? tally + TALLY_W'(1) : tally;
  assign pos_inc    = TALLY_W'(position) + TALLY_W'(1);
  assign window_end = (pos_inc >= len_eff);

  always_comb begin
    if (readings == '0) begin
      len_eff = TALLY_W'(1);
    end else if (TALLY_W'(readings) > TALLY_W'(MAX_READINGS)) begin
      len_eff = TALLY_W'(MAX_READINGS);
    end else begin
      len_eff = TALLY_W'(readings);
    end
  end

  // Restoring divider step
  assign div_shift = {rem, quot[SUM_W-1]};
  assign div_ok    = (div_shift >= {1'b0, tally});
  assign div_diff  = div_shift - {1'b0, tally};

  assign out_free   = !out_valid || !out_stall;
  assign step_state = (state == ST_LOG_SQ) || (state == ST_EXP_MUL) || (state == ST_DIV);
  assign last_step  = (state == ST_DIV) ? (cnt == STEP_W'(SUM_W - 1))
                                        : (cnt == STEP_W'(LOG_FRAC_W - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_LOG_INIT;
      ST_LOG_INIT:  state_next = raw_zero ? ST_GATE_MUL : ST_LOG_SQ;
      ST_LOG_SQ:    if (last_step) state_next = ST_SLOPE;
      ST_SLOPE:     state_next = ST_EXP_SETUP;
      ST_EXP_SETUP: state_next = (exp_neg || exp_big) ? ST_GATE_MUL : ST_EXP_MUL;
      ST_EXP_MUL:   if (last_step) state_next = ST_EXP_OUT;
      ST_EXP_OUT:   state_next = ST_GATE_MUL;
      ST_GATE_MUL:  state_next = ST_GATE;
      ST_GATE: begin
        if (!window_end) begin
          state_next = ST_IDLE;
        end else begin
          state_next = (tally_new == '0) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV:       if (last_step) state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Handshake and multiplier operand select
  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_LOG_SQ: begin
        mul_a = x;
        mul_b = x;
      end
      ST_SLOPE: begin
        mul_a = MANT_W'(CURVE_SLOPE[curve_sel]);
        mul_b = MANT_W'({log_int, frac});
      end
      ST_EXP_MUL: begin
        mul_a = m;
        mul_b = EXP_ROOT[cnt];
      end
      ST_GATE_MUL: begin
        mul_a = MANT_W'(tolerance);
        mul_b = MANT_W'(prev);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control state, configuration and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      out_valid    <= 1'b0;
      sensor_curve <= '0;
      readings     <= READINGS_RESET;
      tolerance    <= '0;
      prev         <= '0;
      sum          <= '0;
      tally        <= '0;
      position     <= '0;
    end else begin
      state <= state_next;
      cnt   <= (step_state && state_next == state) ? cnt + STEP_W'(1) : '0;

      // Write configuration
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_SENSOR_CURVE: sensor_curve <= cfg_data[CURVE_W-1:0];
          CFG_READINGS:     readings     <= cfg_data;
          CFG_TOLERANCE:    tolerance    <= cfg_data;
          default: ;
        endcase
      end

      // Load the output item, or drop it once taken
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Update history and window
      if (state == ST_GATE) begin
        if (pass) prev <= distance;
        sum      <= sum_new;
        tally    <= tally_new;
        position <= window_end ? '0 : pos_inc[POS_W-1:0];
      end

      // Close the window
      if (state == ST_OUT && out_free) begin
        sum       <= '0;
        tally     <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) raw_q <= raw_sample[ADC_BITS-1:0];
      end
      ST_LOG_INIT: begin
        x        <= norm_wide[MANT_W-1:0];
        log_int  <= lead;
        frac     <= '0;
        distance <= DIST_MAX;
      end
      ST_LOG_SQ: begin
        x    <= x_next;
        frac <= {frac[LOG_FRAC_W-2:0], sq[MANT_W]};
      end
      ST_SLOPE: begin
        expo <= prod[LOG_FRAC_W +: TOP_W];
      end
      ST_EXP_SETUP: begin
        frac     <= exp_diff[LOG_FRAC_W-1:0];
        shift_n  <= exp_diff[LOG_FRAC_W +: SHIFT_W];
        m        <= MANT_W'(1) << Q_FRAC;
        distance <= exp_neg ? '0 : DIST_MAX;
      end
      ST_EXP_MUL: begin
        if (frac[LOG_FRAC_W-1]) m <= prod[Q_FRAC +: MANT_W];
        frac <= {frac[LOG_FRAC_W-2:0], 1'b0};
      end
      ST_EXP_OUT: begin
        distance <= shifted_m[Q_FRAC +: DIST_W];
      end
      ST_GATE_MUL: begin
        tol_prod <= prod[GATE_W-1:0];
      end
      ST_GATE: begin
        quot <= sum_new;
        rem  <= '0;
      end
      ST_DIV: begin
        quot <= {quot[SUM_W-2:0], div_ok};
        rem  <= div_ok ? div_diff[TALLY_W-1:0] : div_shift[TALLY_W-1:0];
      end
      ST_OUT: begin
        if (out_free) begin
          mean_distance     <= quot[DIST_W-1:0];
          accepted_readings <= tally;
          none_accepted     <= (tally == '0);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: dv/ir_range_linearize_gated_average_unit_test.sv
`default_nettype none

module ir_range_linearize_gated_average_unit_test;
  import irlga_pkg::*;

  // Spare register index: no register behind it, writes are dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  // Curve coefficients as decimals scaled by 1e10
  localparam logic [63:0] E10_SCALE   = 64'd10000000000;
  localparam logic [63:0] E10_LOG2_10 = 64'd33219280949;
  localparam logic [63:0] E10_OFFSET [6] = '{
    64'd36515057200, 64'd38809406350, 64'd36067410490,
    64'd40164180500, 64'd43216189610, 64'd42230622890
  };
  localparam logic [63:0] E10_SLOPE [6] = '{
    64'd9696596938,  64'd10502688370, 64'd9444125255,
    64'd11067601980, 64'd10973048770, 64'd10593915270
  };

  typedef enum int {
    RAW_UNIFORM,
    RAW_JITTER,
    RAW_DRIFT
  } raw_style_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_style_t;

  typedef struct {
    logic [DIST_W-1:0]  mean;
    logic [TALLY_W-1:0] tally;
    logic               empty;
  } window_mean_t;

  // Tracks the gated window mean and checks each result against it
  class window_mean_tracker;
    logic [CURVE_W-1:0]    curve_sel;
    logic [CFG_DATA_W-1:0] window_len;
    logic [CFG_DATA_W-1:0] tol_pct;
    logic [DIST_W-1:0]     last_dist;
    logic [SUM_W-1:0]      dist_sum;
    logic [TALLY_W-1:0]    dist_tally;
    int unsigned           position;
    logic [63:0]           exp_roots [24];
    window_mean_t          expected_means [$];
    int unsigned           errors;

    function new();
      logic [63:0] rt;
      curve_sel  = '0;
      window_len = READINGS_RESET;
      tol_pct    = '0;
      last_dist  = '0;
      dist_sum   = '0;
      dist_tally = '0;
      position   = 0;
      errors     = 0;
      rt = floor_sqrt(64'd1 << 61);
      for (int i = 0; i < 24; i++) begin
        exp_roots[i] = rt;
        rt = floor_sqrt(rt << 30);
      end
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] e10_to_q24(logic [63:0] dec);
      return (dec << 24) / E10_SCALE;
    endfunction

    // log2 in Q.24: integer part from the leading one, fraction by squaring
    function logic [63:0] log2_q24(logic [RAW_W-1:0] v);
      int unsigned msb;
      logic [63:0] x;
      logic [63:0] frac;
      msb  = 0;
      frac = '0;
      while (msb < RAW_W - 1 && (v >> (msb + 1)) != 0) msb++;
      x = (64'(v) << 30) >> msb;
      for (int i = 0; i < 24; i++) begin
        x    = (x * x) >> 30;
        frac = frac << 1;
        if (x >= (64'd2 << 30)) begin
          x    = x >> 1;
          frac = frac | 64'd1;
        end
      end
      return (64'(msb) << 24) | frac;
    endfunction

    // Distance in cm, Q12.4, from one sample on the selected curve
    function logic [DIST_W-1:0] distance_of(logic [RAW_W-1:0] raw, logic [CURVE_W-1:0] sel);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] head;
      logic [63:0] e;
      logic [63:0] m;
      logic [63:0] v;
      int unsigned c;
      int unsigned n;
      if (raw == 0) return DIST_MAX;
      c    = (sel > CURVE_W'(CURVE_LAST)) ? 32'(CURVE_LAST) : 32'(sel);
      a    = (e10_to_q24(E10_OFFSET[c]) * e10_to_q24(E10_LOG2_10)) >> 24;
      b    = (e10_to_q24(E10_SLOPE[c]) * log2_q24(raw)) >> 24;
      head = a + (64'(FRAC_BITS) << 24);
      if (head < b) return '0;
      e = head - b;
      n = 32'(e >> 24);
      if (n >= DIST_W) return DIST_MAX;
      m = 64'd1 << 30;
      for (int i = 1; i <= 24; i++) begin
        if (e[24-i]) m = (m * exp_roots[i-1]) >> 30;
      end
      v = (m << n) >> 30;
      return (v > 64'(DIST_MAX)) ? DIST_MAX : v[DIST_W-1:0];
    endfunction

    function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SENSOR_CURVE: curve_sel  = data[CURVE_W-1:0];
        CFG_READINGS:     window_len = data;
        CFG_TOLERANCE:    tol_pct    = data;
        default: ;
      endcase
    endfunction

    // Gate the sample, update the window and queue a mean at window end
    function void note_sample(logic [RAW_W-1:0] raw);
      logic [DIST_W-1:0] sample_dist;
      int unsigned       span;
      window_mean_t      res;
      sample_dist = distance_of(raw, curve_sel);
      span = (window_len == 0) ? 1 : (window_len > MAX_READINGS) ? MAX_READINGS : window_len;
      if (64'(sample_dist) * 100 >= 64'(tol_pct) * 64'(last_dist)) begin
        last_dist  = sample_dist;
        dist_sum   = dist_sum + SUM_W'(sample_dist);
        dist_tally = dist_tally + TALLY_W'(1);
      end
      position++;
      if (position < span) return;
      res.mean  = (dist_tally != 0) ? DIST_W'(dist_sum / dist_tally) : '0;
      res.tally = dist_tally;
      res.empty = (dist_tally == 0);
      expected_means.push_back(res);
      dist_sum   = '0;
      dist_tally = '0;
      position   = 0;
    endfunction

    function void check_result(logic [DIST_W-1:0] mean, logic [TALLY_W-1:0] tally,
                               logic empty);
      window_mean_t want;
      if (expected_means.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: mean %0d tally %0d empty %0b",
                 $time, mean, tally, empty);
        return;
      end
      want = expected_means.pop_front();
      if (mean !== want.mean) begin
        errors++;
        $display("%0t: mean_distance expected %0d actual %0d", $time, want.mean, mean);
      end
      if (tally !== want.tally) begin
        errors++;
        $display("%0t: accepted_readings expected %0d actual %0d", $time, want.tally, tally);
      end
      if (empty !== want.empty) begin
        errors++;
        $display("%0t: none_accepted expected %0b actual %0b", $time, want.empty, empty);
      end
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [RAW_W-1:0]       raw_sample   = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [DIST_W-1:0]      mean_distance;
  logic [TALLY_W-1:0]     accepted_readings;
  logic                   none_accepted;

  window_mean_tracker tracker;
  int unsigned        burst_left   = 0;
  int unsigned        samples_sent = 0;
  stall_style_t       stall_style  = STALL_NONE;
  int unsigned        stall_left   = 0;
  int unsigned        cycle_count  = 0;

  ir_range_linearize_gated_average_unit u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .raw_sample        (raw_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .mean_distance     (mean_distance),
    .accepted_readings (accepted_readings),
    .none_accepted     (none_accepted)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check results first, then note the item accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tracker.check_result(mean_distance, accepted_readings, none_accepted);
      end
      if (in_valid && !in_stall) begin
        tracker.note_sample(raw_sample);
      end
    end
  end

  // Receiver back-pressure: switch between free, random and periodic stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stall_left == 0) begin
      stall_style <= stall_style_t'($urandom_range(0, 2));
      stall_left  <= $urandom_range(200, 800);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default:      out_stall <= ((cycle_count % 16) < 7);
    endcase
  end

  // Present one sample, idling between bursts, and hold it until accepted
  task automatic send_sample(input logic [RAW_W-1:0] raw, input bit gaps_on);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    in_valid   <= 1'b1;
    raw_sample <= raw;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // Stop sending and wait for every pending mean plus the block's latency
  task automatic drain_block();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // Write all three registers back to back, optionally poke the spare index
  task automatic apply_config(input logic [CFG_DATA_W-1:0] curve_data,
                              input logic [CFG_DATA_W-1:0] len_data,
                              input logic [CFG_DATA_W-1:0] tol_data,
                              input bit spare_write);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  val [4];
    int unsigned            n;
    idx[0] = CFG_SENSOR_CURVE;
    val[0] = curve_data;
    idx[1] = CFG_READINGS;
    val[1] = len_data;
    idx[2] = CFG_TOLERANCE;
    val[2] = tol_data;
    idx[3] = CFG_SPARE;
    val[3] = CFG_DATA_W'($urandom());
    n = spare_write ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index    <= idx[i];
      cfg_data     <= val[i];
      @(posedge clk);
      tracker.note_config(idx[i], val[i]);
    end
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // One random setting followed by a stream of shaped samples
  task automatic run_random_phase();
    logic [CFG_DATA_W-1:0] len_data;
    logic [CFG_DATA_W-1:0] tol_data;
    logic [RAW_W-1:0]      raw;
    raw_style_t            style;
    int unsigned           pick;
    int unsigned           count;
    int                    level;
    bit                    gaps_on;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: len_data = 7'd0;
        1: len_data = 7'd1;
        2: len_data = 7'(MAX_READINGS);
        default: len_data = 7'd127;
      endcase
    end else if (pick < 3) begin
      len_data = 7'($urandom_range(13, 40));
    end else begin
      len_data = 7'($urandom_range(1, 12));
    end
    case ($urandom_range(0, 7))
      0: tol_data = 7'd0;
      1: tol_data = 7'd100;
      2: tol_data = 7'd127;
      3: tol_data = 7'($urandom_range(101, 126));
      4: tol_data = 7'($urandom_range(0, 100));
      default: tol_data = 7'($urandom_range(85, 99));
    endcase
    apply_config({4'($urandom()), 3'($urandom_range(0, 7))}, len_data, tol_data,
                 ($urandom_range(0, 7) == 0));
    style   = raw_style_t'($urandom_range(0, 2));
    level   = $urandom_range(0, 1023);
    gaps_on = ($urandom_range(0, 3) != 0);
    count   = $urandom_range(30, 120);
    for (int k = 0; k < count; k++) begin
      case (style)
        RAW_UNIFORM: level = $urandom_range(0, 1023);
        RAW_JITTER:  level = level + int'($urandom_range(0, 60)) - 30;
        default:     level = level + int'($urandom_range(0, 8)) - 2;
      endcase
      if (level < 0) level = 0;
      if (level > 1023) level = 1023;
      pick = $urandom_range(0, 39);
      raw  = (pick == 0) ? '0 : (pick == 1) ? '1 : RAW_W'(level);
      send_sample(raw, gaps_on);
    end
    drain_block();
  endtask

  initial begin
    logic [RAW_W-1:0] edge_raws [25];
    edge_raws = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1023, 10'd1022, 10'd512, 10'd511,
                  10'd256, 10'd255, 10'd128, 10'd127, 10'd64, 10'd63, 10'd32, 10'd31,
                  10'd16, 10'd15, 10'd8, 10'd7, 10'd4, 10'd5, 10'd682, 10'd341, 10'd1000};
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: one full window of field extremes
    foreach (edge_raws[i]) send_sample(edge_raws[i], 1'b1);
    drain_block();

    // Full tolerance after a saturated reading: one accepted, then an empty window
    apply_config(7'd4, 7'd4, 7'd100, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd100, 1'b0);
    send_sample(10'd200, 1'b0);
    send_sample(10'd300, 1'b0);
    repeat (4) send_sample(10'd500, 1'b0);
    drain_block();

    // Shorten the window while partly filled: the next sample closes it
    apply_config(7'd3, 7'd8, 7'd0, 1'b1);
    repeat (5) send_sample(RAW_W'($urandom_range(1, 1023)), 1'b1);
    drain_block();
    apply_config(7'd3, 7'd2, 7'd0, 1'b0);
    repeat (4) send_sample(RAW_W'($urandom_range(0, 1023)), 1'b1);
    drain_block();

    // Random settings and sample streams
    while (samples_sent < 1600) run_random_phase();

    drain_block();
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
